/* hdl/chebyshev_series_evaluator_top_macros.svh */
// Assertion helpers for the evaluator, clocked on clock, off during reset.
`ifndef CHEBYSHEV_SERIES_EVALUATOR_TOP_MACROS_SVH
`define CHEBYSHEV_SERIES_EVALUATOR_TOP_MACROS_SVH

// Same-cycle implication.
`define CSE_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication.
`define CSE_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

/* hdl/cse_pkg.sv */
`timescale 1ns / 1ps

package cse_pkg;

   localparam int DEFAULT_MAX_DEGREE = 32;

   localparam int COEF_IDX_W = 6;
   localparam int Q_W        = 32;
   localparam int SAT_W      = 48;   // wide enough for every pre-clamp sum

   // configuration register indexes
   localparam logic [1:0] CSR_DEGREE = 2'd0;
   localparam logic [1:0] CSR_CENTER = 2'd1;
   localparam logic [1:0] CSR_IHW    = 2'd2;

   localparam logic [COEF_IDX_W-1:0] DEGREE_RESET = 6'd1;
   localparam logic [Q_W-1:0]        CENTER_RESET = 32'h0000_0000;
   localparam logic [Q_W-1:0]        IHW_RESET    = 32'h0100_0000;   // 1.0 in Q8.24

   localparam logic MODE_LOAD = 1'b0;
   localparam logic MODE_EVAL = 1'b1;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCALE,
      ST_STEP,
      ST_FINAL
   } cse_state_type;

   typedef struct packed {
      logic                  wr_en;
      logic [COEF_IDX_W-1:0] wr_addr;
      logic                  rd_en;
      logic [COEF_IDX_W-1:0] rd_addr;
      logic                  start;
      logic                  scale;
      logic                  step;
   } cse_ctrl_type;

   typedef struct packed {
      logic [Q_W-1:0] value;
      logic           ovf;
   } cse_sat_type;

   localparam logic signed [SAT_W-1:0] SAT_HI = 48'sd2147483647;
   localparam logic signed [SAT_W-1:0] SAT_LO = -48'sd2147483648;

   function automatic cse_sat_type sat32(input logic signed [SAT_W-1:0] v);
      cse_sat_type r;
      if (v > SAT_HI) begin
         r.value = SAT_HI[Q_W-1:0];
         r.ovf   = 1'b1;
      end else if (v < SAT_LO) begin
         r.value = SAT_LO[Q_W-1:0];
         r.ovf   = 1'b1;
      end else begin
         r.value = v[Q_W-1:0];
         r.ovf   = 1'b0;
      end
      return r;
   endfunction

endpackage

/* hdl/chebyshev_series_evaluator_top.sv */
`timescale 1ns / 1ps
// Channel  | Direction | Ports                          | Contents
// req      | in        | req_tvalid/tready/tdata/tuser  | tdata: coef_index, coef_value, point
//          |           |                                | tuser: mode
// rsp      | out       | rsp_tvalid/tready/tdata/tuser  | tdata: series_value, tuser: overflow
// csr      | in        | csr_we/csr_index/csr_wdata     | degree, center, inverse_half_width
//
// A load writes the coefficient RAM when it is accepted. An evaluation of degree n runs:
// accept, scale multiply, one Clenshaw step per cycle through the coefficient RAM's
// single read port, then the final combine into the output register.
// Degree 0 skips the scale and the steps. Reset is synchronous and clears control state only;
// the coefficient RAM holds no reset value. A result still waiting in the output
// register holds the next evaluation in its final combine, with req_tready low,
// until rsp_tready frees the slot; transactions before that point go on as usual.

module chebyshev_series_evaluator_top import cse_pkg::*; #(
   parameter int MAX_DEGREE = DEFAULT_MAX_DEGREE
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [71:0] req_tdata,   // [5:0] coef_index, [37:6] coef_value, [69:38] point
   input  logic        req_tuser,   // [0] mode
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata,   // [31:0] series_value
   output logic        rsp_tuser,   // [0] overflow
   input  logic        csr_we,
   input  logic [1:0]  csr_index,
   input  logic [31:0] csr_wdata
);

   `include "chebyshev_series_evaluator_top_macros.svh"

   localparam int                    AW      = $clog2(MAX_DEGREE + 1);
   localparam logic [COEF_IDX_W-1:0] MAX_IDX = COEF_IDX_W'(MAX_DEGREE);

   logic [COEF_IDX_W-1:0] degree_ff, degree_in;
   logic [Q_W-1:0]        center_ff, center_in;
   logic [Q_W-1:0]        ihw_ff, ihw_in;

   always_comb begin
      degree_in = degree_ff;
      center_in = center_ff;
      ihw_in    = ihw_ff;
      if (csr_we) begin
         case (csr_index)
            CSR_DEGREE: degree_in = csr_wdata[COEF_IDX_W-1:0];
            CSR_CENTER: center_in = csr_wdata;
            CSR_IHW:    ihw_in    = csr_wdata;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         degree_ff <= DEGREE_RESET;
         center_ff <= CENTER_RESET;
         ihw_ff    <= IHW_RESET;
      end else begin
         degree_ff <= degree_in;
         center_ff <= center_in;
         ihw_ff    <= ihw_in;
      end
   end

   logic [COEF_IDX_W-1:0] req_index;
   logic [Q_W-1:0]        req_coef, req_point;
   logic                  req_mode, req_accept;

   assign req_index  = req_tdata[5:0];
   assign req_coef   = req_tdata[37:6];
   assign req_point  = req_tdata[69:38];
   assign req_mode   = req_tuser;
   assign req_accept = req_tvalid & req_tready;

   logic [AW-1:0] n_clamped;
   assign n_clamped = (degree_ff > MAX_IDX) ? AW'(MAX_DEGREE) : degree_ff[AW-1:0];

   cse_state_type state_ff, state_in;
   logic [AW-1:0] k_ff, k_in;
   cse_ctrl_type  ctrl;
   logic          out_load;
   logic          rsp_valid_ff, rsp_valid_in;
   logic [Q_W-1:0] rsp_value_ff, rsp_value_in;
   logic          rsp_ovf_ff, rsp_ovf_in;
   logic [Q_W-1:0] final_value;
   logic          final_ovf;
   logic          out_free;

   assign out_free   = ~rsp_valid_ff | rsp_tready;
   assign req_tready = (state_ff == ST_IDLE);

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_accept && req_mode == MODE_EVAL) begin
               state_in = (n_clamped == '0) ? ST_FINAL : ST_SCALE;
            end
         end
         ST_SCALE: state_in = ST_STEP;
         ST_STEP: begin
            if (k_ff == AW'(1)) begin
               state_in = ST_FINAL;
            end
         end
         ST_FINAL: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // controls
   always_comb begin
      ctrl     = '0;
      k_in     = k_ff;
      out_load = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            if (req_accept) begin
               if (req_mode == MODE_LOAD) begin
                  ctrl.wr_en   = (req_index <= MAX_IDX);
                  ctrl.wr_addr = req_index;
               end else begin
                  ctrl.start = 1'b1;
                  k_in       = n_clamped;
                  if (n_clamped == '0) begin
                     ctrl.rd_en   = 1'b1;
                     ctrl.rd_addr = '0;
                  end
               end
            end
         end
         ST_SCALE: begin
            ctrl.scale   = 1'b1;
            ctrl.rd_en   = 1'b1;
            ctrl.rd_addr = COEF_IDX_W'(k_ff);
         end
         ST_STEP: begin
            ctrl.step    = 1'b1;
            ctrl.rd_en   = 1'b1;
            ctrl.rd_addr = COEF_IDX_W'(k_ff - AW'(1));
            k_in         = k_ff - AW'(1);
         end
         ST_FINAL: out_load = out_free;
         default: ;
      endcase
   end

   cse_datapath #(
      .MAX_DEGREE(MAX_DEGREE)
   ) u_datapath (
      .clock              (clock),
      .ctrl               (ctrl),
      .coef_value         (req_coef),
      .point              (req_point),
      .center             (center_ff),
      .inverse_half_width (ihw_ff),
      .final_value        (final_value),
      .final_ovf          (final_ovf)
   );

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_value_in = rsp_value_ff;
      rsp_ovf_in   = rsp_ovf_ff;
      if (out_load) begin
         rsp_valid_in = 1'b1;
         rsp_value_in = final_value;
         rsp_ovf_in   = final_ovf;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         k_ff         <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         k_ff         <= k_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_value_ff <= rsp_value_in;
      rsp_ovf_ff   <= rsp_ovf_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_value_ff;
   assign rsp_tuser  = rsp_ovf_ff;

   `CSE_ASSERT_NOW(a_step_count_nonzero, state_ff == ST_STEP, k_ff != '0, "step with zero count")
   `CSE_ASSERT_NEXT(a_final_fills_output, out_load, rsp_tvalid, "final combine lost result")
   `CSE_ASSERT_NOW(a_final_waits_slot, out_load, !rsp_valid_ff || rsp_tready, "result overwritten")

endmodule

/* hdl/cse_datapath.sv */
`timescale 1ns / 1ps

module cse_datapath import cse_pkg::*; #(
   parameter int MAX_DEGREE = DEFAULT_MAX_DEGREE
) (
   input  logic                  clock,
   input  cse_ctrl_type          ctrl,
   input  logic signed [Q_W-1:0] coef_value,
   input  logic signed [Q_W-1:0] point,
   input  logic signed [Q_W-1:0] center,
   input  logic signed [Q_W-1:0] inverse_half_width,
   output logic [Q_W-1:0]        final_value,
   output logic                  final_ovf
);

   localparam int AW = $clog2(MAX_DEGREE + 1);

   localparam logic signed [64:0] RND_SCALE = 65'sd8388608;   // half of 2^24
   localparam logic signed [63:0] RND_STEP  = 64'sd4194304;   // half of 2^23
   localparam logic signed [63:0] RND_FINAL = 64'sd8388608;

   logic signed [Q_W-1:0] coef_mem [0:MAX_DEGREE];
   logic signed [Q_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (ctrl.wr_en) begin
         coef_mem[ctrl.wr_addr[AW-1:0]] <= coef_value;
      end
      if (ctrl.rd_en) begin
         rd_data_ff <= coef_mem[ctrl.rd_addr[AW-1:0]];
      end
   end

   logic signed [32:0]    diff_ff, diff_in;
   logic signed [Q_W-1:0] s_ff, s_in;
   logic signed [Q_W-1:0] b1_ff, b1_in;
   logic signed [Q_W-1:0] b2_ff, b2_in;
   logic                  ovf_ff, ovf_in;

   // s = round((x - center) * ihw / 2^24)
   logic signed [64:0]    scale_prod, scale_sh;
   cse_sat_type           s_sat;

   assign scale_prod = diff_ff * inverse_half_width;
   assign scale_sh   = (scale_prod + RND_SCALE) >>> 24;
   assign s_sat      = sat32(scale_sh[SAT_W-1:0]);

   // one shared multiplier for the recurrence and the final combine
   logic signed [63:0]    prod, step_sh, final_sh;
   logic signed [SAT_W-1:0] step_r, final_r, b2_x, c_x, step_t, final_t;
   cse_sat_type           step_sat, final_sat;

   assign prod     = s_ff * b1_ff;
   assign step_sh  = (prod + RND_STEP) >>> 23;    // 2*s*b1
   assign final_sh = (prod + RND_FINAL) >>> 24;   // s*b1
   assign step_r   = step_sh[SAT_W-1:0];
   assign final_r  = final_sh[SAT_W-1:0];
   assign b2_x     = SAT_W'(b2_ff);
   assign c_x      = SAT_W'(rd_data_ff);
   assign step_t   = step_r - b2_x + c_x;
   assign final_t  = c_x + final_r - b2_x;
   assign step_sat  = sat32(step_t);
   assign final_sat = sat32(final_t);

   always_comb begin
      diff_in = diff_ff;
      s_in    = s_ff;
      b1_in   = b1_ff;
      b2_in   = b2_ff;
      ovf_in  = ovf_ff;
      if (ctrl.start) begin
         diff_in = {point[Q_W-1], point} - {center[Q_W-1], center};
         b1_in   = '0;
         b2_in   = '0;
         ovf_in  = 1'b0;
      end
      if (ctrl.scale) begin
         s_in   = s_sat.value;
         ovf_in = ovf_ff | s_sat.ovf;
      end
      if (ctrl.step) begin
         b2_in  = b1_ff;
         b1_in  = step_sat.value;
         ovf_in = ovf_ff | step_sat.ovf;
      end
   end

   always_ff @(posedge clock) begin
      diff_ff <= diff_in;
      s_ff    <= s_in;
      b1_ff   <= b1_in;
      b2_ff   <= b2_in;
      ovf_ff  <= ovf_in;
   end

   assign final_value = final_sat.value;
   assign final_ovf   = ovf_ff | final_sat.ovf;

endmodule

/* verif/tb_top.sv */
`timescale 1ns / 1ps

module tb_top import cse_pkg::*;;

   localparam int            MAX_DEG      = DEFAULT_MAX_DEGREE;
   localparam int            DRAIN_CYCLES = 40;     // longest evaluation plus margin
   localparam int            STALL_LIMIT  = 2000;
   localparam logic [31:0]   Q_ONE        = 32'h0100_0000;
   localparam logic [31:0]   Q_POS_MAX    = 32'h7FFF_FFFF;
   localparam logic [31:0]   Q_NEG_MAX    = 32'h8000_0000;
   localparam longint        Q_HI         = 64'sd2147483647;
   localparam longint        Q_LO         = -64'sd2147483648;

   typedef struct packed {
      logic [31:0] value;
      logic        ovf;
   } series_out_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [71:0] req_tdata = '0;   // [5:0] coef_index, [37:6] coef_value, [69:38] point
   logic        req_tuser = 1'b0; // [0] mode
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [31:0] rsp_tdata;        // [31:0] series_value
   logic        rsp_tuser;        // [0] overflow
   logic        csr_we = 1'b0;
   logic [1:0]  csr_index = '0;
   logic [31:0] csr_wdata = '0;

   // predictor state
   logic signed [31:0] coef_mem [0:MAX_DEG];
   logic [5:0]         cfg_degree = DEGREE_RESET;
   logic signed [31:0] cfg_center = CENTER_RESET;
   logic signed [31:0] cfg_ihw    = IHW_RESET;

   series_out_type series_due [$];
   int          errors = 0;
   int          stall_cycles = 0;
   bit          gaps_on = 1'b1;

   chebyshev_series_evaluator_top i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   initial begin
      forever #2 clock = ~clock;
   end

   // round to nearest, ties toward +inf
   function automatic longint round_shr(input longint v, input int sh);
      return (v + (longint'(1) <<< (sh - 1))) >>> sh;
   endfunction

   function automatic longint clamp_q(input longint v);
      return (v > Q_HI) ? Q_HI : ((v < Q_LO) ? Q_LO : v);
   endfunction

   // Clenshaw recurrence on the current table and settings
   function automatic series_out_type eval_series(input logic signed [31:0] x);
      series_out_type r;
      int          n;
      int          k;
      longint      s;
      longint      b1;
      longint      b2;
      longint      t;
      longint      v;
      logic        ovf;
      n   = (cfg_degree > MAX_DEG) ? MAX_DEG : int'(cfg_degree);
      ovf = 1'b0;
      if (n == 0) begin
         v = longint'(coef_mem[0]);
      end else begin
         t   = round_shr((longint'(x) - longint'(cfg_center)) * longint'(cfg_ihw), 24);
         s   = clamp_q(t);
         ovf = (s != t);
         b1  = 0;
         b2  = 0;
         for (k = n; k >= 1; k--) begin
            t   = round_shr(s * b1, 23) - b2 + longint'(coef_mem[k]);
            b2  = b1;
            b1  = clamp_q(t);
            ovf = ovf | (b1 != t);
         end
         t   = longint'(coef_mem[0]) + round_shr(s * b1, 24) - b2;
         v   = clamp_q(t);
         ovf = ovf | (v != t);
      end
      r.value = v[31:0];
      r.ovf   = ovf;
      return r;
   endfunction

   function automatic logic [31:0] rand_q(input int span);
      int sel;
      sel = $urandom_range(0, 9);
      if (sel < 7) begin
         return $urandom_range(0, 2 * span) - span;
      end else if (sel < 9) begin
         return $urandom;
      end
      case ($urandom_range(0, 3))
         0: return Q_POS_MAX;
         1: return Q_NEG_MAX;
         2: return 32'h0;
         default: return 32'hFFFF_FFFF;
      endcase
   endfunction

   function automatic logic [31:0] rand_ihw();
      logic [31:0] mag;
      if ($urandom_range(0, 9) < 4) begin
         return rand_q(1 << 30);
      end
      mag = $urandom_range(1 << 22, 1 << 25);
      return $urandom_range(0, 1) ? -mag : mag;
   endfunction

   task automatic report_mismatch(input string msg);
      errors++;
      if (errors <= 40) begin
         $display("ERROR @%0t: %s", $time, msg);
      end
   endtask

   task automatic send_req(input logic mode, input logic [5:0] idx,
                           input logic [31:0] val, input logic [31:0] pt);
      if (gaps_on && $urandom_range(0, 4) == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 18)) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= mode;
      req_tdata  <= {2'b00, pt, val, idx};
      do @(posedge clock); while (!req_tready);
      if (mode == MODE_EVAL) begin
         series_due.push_back(eval_series(pt));
      end else if (idx <= MAX_DEG) begin
         coef_mem[idx] = val;
      end
   endtask

   task automatic load_coef(input logic [5:0] idx, input logic [31:0] val);
      send_req(MODE_LOAD, idx, val, $urandom);
   endtask

   task automatic eval_at(input logic [31:0] pt);
      send_req(MODE_EVAL, 6'($urandom), $urandom, pt);
   endtask

   // drain: all results back, then let a trailing load or evaluation settle
   task automatic wait_idle();
      req_tvalid <= 1'b0;
      while (series_due.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic set_config(input logic [5:0] deg, input logic [31:0] ctr,
                             input logic [31:0] ihw);
      logic [31:0] junk;
      junk = $urandom;
      csr_we    <= 1'b1;
      csr_index <= CSR_DEGREE;
      csr_wdata <= {junk[31:6], deg};
      @(posedge clock);
      csr_index <= CSR_CENTER;
      csr_wdata <= ctr;
      @(posedge clock);
      csr_index <= CSR_IHW;
      csr_wdata <= ihw;
      @(posedge clock);
      csr_we <= 1'b0;
      cfg_degree = deg;
      cfg_center = ctr;
      cfg_ihw    = ihw;
   endtask

   // reset settings: degree 1 over [-1,1]
   task automatic test_reset_state();
      load_coef(6'd0, Q_ONE);
      load_coef(6'd1, 32'h0080_0000);
      eval_at(32'h0);
      eval_at(Q_ONE);
      eval_at(-Q_ONE);
   endtask

   // indexes past the table must leave it untouched
   task automatic test_ignored_loads();
      load_coef(6'd33, $urandom);
      load_coef(6'd63, $urandom);
      eval_at($urandom);
   endtask

   task automatic test_coef_extremes();
      wait_idle();
      set_config(6'd2, 32'h0, Q_ONE);
      load_coef(6'd2, Q_POS_MAX);
      load_coef(6'd0, Q_NEG_MAX);
      load_coef(6'd32, Q_NEG_MAX);
      eval_at(Q_POS_MAX);
      eval_at(Q_NEG_MAX);
   endtask

   // mapped point s clamps high, from a positive and from a negative offset and scale
   task automatic test_scale_saturation();
      wait_idle();
      set_config(6'd1, Q_NEG_MAX, Q_POS_MAX);
      eval_at(Q_POS_MAX);
      eval_at(Q_NEG_MAX);
      wait_idle();
      set_config(6'd1, Q_POS_MAX, Q_NEG_MAX);
      eval_at(Q_NEG_MAX);
   endtask

   task automatic test_result_saturation();
      wait_idle();
      set_config(6'd1, 32'h0, Q_ONE);
      load_coef(6'd0, Q_POS_MAX);
      load_coef(6'd1, Q_POS_MAX);
      eval_at(Q_ONE);
      eval_at(32'h0);
   endtask

   // half-LSB products: +0.5 rounds up, -0.5 rounds to zero
   task automatic test_tie_rounding();
      wait_idle();
      set_config(6'd1, 32'h0, 32'h0080_0000);
      load_coef(6'd0, 32'h0);
      load_coef(6'd1, 32'h0080_0000);
      eval_at(32'h0000_0001);
      eval_at(32'hFFFF_FFFF);
   endtask

   // degree 0 skips the mapping entirely, even for a wild point
   task automatic test_degree_zero();
      wait_idle();
      set_config(6'd0, $urandom, $urandom);
      eval_at(Q_POS_MAX);
   endtask

   task automatic test_random_series();
      int          order [0:MAX_DEG];
      int          phase;
      int          done;
      int          i;
      int          j;
      int          tmp;
      logic [5:0]  deg;
      logic [5:0]  idx;
      logic [31:0] ctr;
      logic [31:0] ihw;
      wait_idle();
      set_config(6'd32, 32'h0, Q_ONE);
      for (i = 0; i <= MAX_DEG; i++) order[i] = i;
      for (i = MAX_DEG; i > 0; i--) begin
         j        = $urandom_range(0, i);
         tmp      = order[i];
         order[i] = order[j];
         order[j] = tmp;
      end
      for (i = 0; i <= MAX_DEG; i++) load_coef(6'(order[i]), rand_q(1 << 23));
      for (phase = 0; phase < 10; phase++) begin
         wait_idle();
         case (phase)
            0: deg = 6'd32;
            1: deg = 6'd63;
            2: deg = 6'd0;
            3: deg = 6'd33;
            4, 5: deg = 6'($urandom_range(1, 32));
            default: deg = 6'($urandom_range(1, 12));
         endcase
         if (phase == 4) begin
            ctr = Q_NEG_MAX;
            ihw = Q_POS_MAX;
         end else if (phase == 5) begin
            ctr = Q_POS_MAX;
            ihw = Q_NEG_MAX;
         end else begin
            ctr = rand_q(1 << 26);
            ihw = rand_ihw();
         end
         if (phase == 9) gaps_on = 1'b0;
         set_config(deg, ctr, ihw);
         done = 0;
         while (done < 60) begin
            if ($urandom_range(0, 9) < 6) begin
               if ($urandom_range(0, 9) < 8) eval_at(cfg_center + rand_q(1 << 24));
               else eval_at($urandom);
               done++;
            end else begin
               idx = ($urandom_range(0, 9) < 9) ? 6'($urandom_range(0, MAX_DEG))
                                                : 6'($urandom_range(MAX_DEG + 1, 63));
               load_coef(idx, rand_q(1 << 23));
               if (idx <= MAX_DEG) done++;
            end
         end
      end
   endtask

   initial begin : rsp_pacer
      while (reset) @(posedge clock);
      forever begin
         if (gaps_on && $urandom_range(0, 3) == 0) begin
            rsp_tready <= 1'b0;
            repeat ($urandom_range(1, 18)) @(posedge clock);
         end
         rsp_tready <= 1'b1;
         repeat ($urandom_range(1, 24)) @(posedge clock);
      end
   end

   always @(posedge clock) begin
      series_out_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (series_due.size() == 0) begin
            report_mismatch($sformatf("unexpected result %h ovf %b", rsp_tdata, rsp_tuser));
         end else begin
            want = series_due.pop_front();
            if (rsp_tdata !== want.value) begin
               report_mismatch($sformatf("series_value got %h expected %h",
                                         rsp_tdata, want.value));
            end
            if (rsp_tuser !== want.ovf) begin
               report_mismatch($sformatf("overflow got %b expected %b (value %h)",
                                         rsp_tuser, want.ovf, want.value));
            end
         end
      end
   end

   // no transaction of any kind for too long means a hang
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) || csr_we) begin
         stall_cycles <= 0;
      end else begin
         stall_cycles <= stall_cycles + 1;
      end
      if (stall_cycles == STALL_LIMIT) begin
         $display("Test completed with failures");
         $finish;
      end
   end

   initial begin
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      test_reset_state();
      test_ignored_loads();
      test_coef_extremes();
      test_scale_saturation();
      test_result_saturation();
      test_tie_rounding();
      test_degree_zero();
      test_random_series();
      wait_idle();
      if (series_due.size() != 0) begin
         report_mismatch($sformatf("%0d results never arrived", series_due.size()));
      end
      if (errors == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule
